### rtl/core/fbpa_pkg.sv
// Package for the fixed-block pool allocator core.
// Holds the beat types, status and operation codes and the default pool size.
// No dependencies.
package fbpa_pkg;

   localparam int NUM_BLOCKS_DEFAULT = 256;

   localparam int INDEX_W  = 8;
   localparam int COUNT_W  = 9;
   localparam int STATUS_W = 2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;
   localparam logic [STATUS_W-1:0] ST_UNUSED = 2'd3;

   typedef struct packed {
      logic               op;
      logic [INDEX_W-1:0] block_index;
   } fbpa_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  granted_index;
      logic [COUNT_W-1:0]  blocks_free;
   } fbpa_rsp_type;

endpackage

### rtl/core/fixed_block_pool_allocator_core.sv
// Fixed-block pool allocator core: a free list of block indexes kept in one block memory.
// Depends on fbpa_pkg for the beat types, codes and the default pool size.
//
// Every request beat runs in two steps: first the memory entry of the list head
// (allocate) or of the named block (free) is read, then the entry is resolved,
// written back and the result is loaded into the output register. req_stall is high
// while a beat runs, so no new request is taken before the last one is resolved. A new
// request is taken while a finished result still waits in the output register; only a
// result that is stalled when the next one is ready holds the resolve step. Each memory
// word holds the in-use flag and the next link of one block. A frontier counter marks
// the blocks not touched since the last rebuild, whose words read as "free, links to the
// next index", so neither reset nor a write of the active count needs a clearing pass.

module fixed_block_pool_allocator_core
   import fbpa_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  fbpa_req_type        req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output fbpa_rsp_type        rsp_data,
   input  logic                csr_write_en,
   input  logic [COUNT_W-1:0]  csr_write_data
);

   localparam int IDX_W = $clog2(NUM_BLOCKS);
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
   // Working width for compares between port fields and internal counts.
   localparam int AW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int MEM_W = IDX_W + 1;

   localparam logic [AW-1:0] NUM_BLOCKS_AW = AW'(NUM_BLOCKS);

   // Block memory: {in_use, next_link}.
   logic [MEM_W-1:0] mem [NUM_BLOCKS];
   logic [MEM_W-1:0] rdata_ff;
   logic             mem_re;
   logic [IDX_W-1:0] mem_raddr;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [MEM_W-1:0] mem_wdata;

   logic [CNT_W-1:0] active_ff, active_in;
   logic [IDX_W-1:0] head_ff,   head_in;
   logic [CNT_W-1:0] free_ff,   free_in;
   logic [CNT_W-1:0] fresh_ff,  fresh_in;
   logic             exec_ff,   exec_in;
   logic             op_ff,     op_in;
   logic [IDX_W-1:0] addr_ff,   addr_in;
   logic [AW-1:0]    idx_ff,    idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   fbpa_rsp_type     rsp_data_ff,  rsp_data_in;

   logic             accept;
   logic             finish;
   logic [AW-1:0]    wr_value;
   logic [AW-1:0]    head_aw;
   logic [AW-1:0]    addr_aw;
   logic [AW-1:0]    addr_next;
   logic [AW-1:0]    active_aw;
   logic             virgin;
   logic             in_use_eff;
   logic [IDX_W-1:0] link_eff;
   logic             pool_empty;
   logic             free_bad;

   function automatic logic [COUNT_W-1:0] wr_trunc(input logic [CNT_W-1:0] v);
      logic [AW-1:0] w;
      w = AW'(v);
      return w[COUNT_W-1:0];
   endfunction

   assign req_stall = exec_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign accept = req_valid && !exec_ff;
   assign finish = exec_ff && (!rsp_valid_ff || !rsp_stall);

   assign head_aw   = AW'(head_ff);
   assign addr_aw   = AW'(addr_ff);
   assign addr_next = addr_aw + AW'(1);
   assign active_aw = AW'(active_ff);

   // Blocks at or above the frontier still hold their rebuild contents.
   assign virgin     = addr_aw >= AW'(fresh_ff);
   assign in_use_eff = virgin ? 1'b0 : rdata_ff[MEM_W-1];
   assign link_eff   = virgin ? ((addr_next < active_aw) ? addr_next[IDX_W-1:0] : '0)
                              : rdata_ff[IDX_W-1:0];

   assign pool_empty = (free_ff == '0) || (head_aw >= active_aw);
   assign free_bad   = (idx_ff >= active_aw) || !in_use_eff;

   always_comb begin
      wr_value = AW'(csr_write_data);
      if (wr_value == '0) begin
         wr_value = AW'(1);
      end else if (wr_value > NUM_BLOCKS_AW) begin
         wr_value = NUM_BLOCKS_AW;
      end
   end

   always_comb begin
      active_in    = active_ff;
      head_in      = head_ff;
      free_in      = free_ff;
      fresh_in     = fresh_ff;
      exec_in      = exec_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_re       = 1'b0;
      mem_raddr    = head_ff;
      mem_we       = 1'b0;
      mem_waddr    = addr_ff;
      mem_wdata    = {1'b1, link_eff};

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         exec_in = 1'b1;
         op_in   = req_data.op;
         idx_in  = AW'(req_data.block_index);
         mem_re  = 1'b1;
         if (req_data.op == OP_ALLOC) begin
            mem_raddr = head_ff;
         end else begin
            mem_raddr = idx_in[IDX_W-1:0];
         end
         addr_in = mem_raddr;
      end

      if (finish) begin
         exec_in                   = 1'b0;
         rsp_valid_in              = 1'b1;
         rsp_data_in.status        = ST_DONE;
         rsp_data_in.granted_index = '0;
         if (op_ff == OP_ALLOC) begin
            if (pool_empty) begin
               rsp_data_in.status = ST_EMPTY;
            end else begin
               rsp_data_in.granted_index = head_aw[INDEX_W-1:0];
               mem_we    = 1'b1;
               mem_wdata = {1'b1, link_eff};
               head_in   = link_eff;
               free_in   = free_ff - CNT_W'(1);
               if (virgin) begin
                  fresh_in = addr_next[CNT_W-1:0];
               end
            end
         end else begin
            if (free_bad) begin
               rsp_data_in.status = ST_REJECT;
            end else begin
               mem_we    = 1'b1;
               mem_wdata = {1'b0, head_ff};
               head_in   = addr_ff;
               free_in   = free_ff + CNT_W'(1);
            end
         end
         rsp_data_in.blocks_free = wr_trunc(free_in);
      end

      if (csr_write_en) begin
         active_in = wr_value[CNT_W-1:0];
         head_in   = '0;
         free_in   = wr_value[CNT_W-1:0];
         fresh_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= CNT_W'(NUM_BLOCKS);
         head_ff      <= '0;
         free_ff      <= CNT_W'(NUM_BLOCKS);
         fresh_ff     <= '0;
         exec_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         fresh_ff     <= fresh_in;
         exec_ff      <= exec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      addr_ff     <= addr_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

endmodule

### rtl/core/fbpa_port_checker.sv
// Port-level checker for the fixed-block pool allocator core, bound to the core module.
// Depends on fbpa_pkg for the beat types and status codes.
module fbpa_port_checker
   import fbpa_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_stall,
   input logic          rsp_valid,
   input logic          rsp_stall,
   input fbpa_rsp_type  rsp_data
);

   // A stalled result beat stays valid and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // Every accepted request stalls the request port while the core resolves it.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted without the read cycle");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status != ST_UNUSED)
      else $error("undefined status code");

   a_no_grant_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_DONE |-> rsp_data.granted_index == '0)
      else $error("granted index set on a failed operation");

   // An empty report can only come from a pool with no free block.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_EMPTY |-> rsp_data.blocks_free == '0)
      else $error("pool reported empty with free blocks left");

endmodule

bind fixed_block_pool_allocator_core fbpa_port_checker u_fbpa_port_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for fixed_block_pool_allocator_core: allocate and free beats
// are checked against a free-list predictor kept in the bench. Depends on fbpa_pkg.
module testbench;
   import fbpa_pkg::*;

   localparam int POOL_SIZE = NUM_BLOCKS_DEFAULT;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   fbpa_req_type        req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   fbpa_rsp_type        rsp_data;
   logic                csr_write_en = 1'b0;
   logic [COUNT_W-1:0]  csr_write_data = '0;

   // Predicted state of the pool.
   int                  pool_active;
   logic [INDEX_W-1:0]  pool_head;
   logic [INDEX_W-1:0]  pool_next [POOL_SIZE];
   bit                  pool_in_use [POOL_SIZE];
   logic [COUNT_W-1:0]  pool_free;

   fbpa_req_type        pending_requests [$];
   fbpa_rsp_type        predicted_rsp [$];
   fbpa_rsp_type        rsp_want;
   int                  requests_queued = 0;
   int                  requests_taken = 0;
   int                  error_count = 0;
   int                  req_gap_left = 0;
   int                  rsp_stall_left = 0;
   bit                  quiet = 1'b0;

   fixed_block_pool_allocator_core #(
      .NUM_BLOCKS(POOL_SIZE)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic void pool_rebuild(input logic [COUNT_W-1:0] value);
      if (value == 0) begin
         pool_active = 1;
      end else if (value > POOL_SIZE) begin
         pool_active = POOL_SIZE;
      end else begin
         pool_active = int'(value);
      end
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_next[i] = (i + 1 < pool_active) ? INDEX_W'(i + 1) : '0;
         pool_in_use[i] = 1'b0;
      end
      pool_head = '0;
      pool_free = COUNT_W'(pool_active);
   endfunction

   function automatic fbpa_rsp_type pool_step(input fbpa_req_type r);
      fbpa_rsp_type o;
      o.status = ST_DONE;
      o.granted_index = '0;
      if (r.op == OP_ALLOC) begin
         if (pool_free == 0 || pool_head >= pool_active) begin
            o.status = ST_EMPTY;
         end else begin
            o.granted_index = pool_head;
            pool_in_use[pool_head] = 1'b1;
            pool_head = pool_next[pool_head];
            pool_free = pool_free - 1'b1;
         end
      end else if (r.block_index >= pool_active || !pool_in_use[r.block_index]) begin
         o.status = ST_REJECT;
      end else begin
         // A freed block goes back on the head of the list.
         pool_in_use[r.block_index] = 1'b0;
         pool_next[r.block_index] = pool_head;
         pool_head = r.block_index;
         pool_free = pool_free + 1'b1;
      end
      o.blocks_free = pool_free;
      return o;
   endfunction

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_rsp.push_back(pool_step(req_data));
            requests_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (req_gap_left > 0) begin
               req_gap_left--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               req_data <= pending_requests.pop_front();
               req_valid <= 1'b1;
               if (!quiet && $urandom_range(0, 7) == 0) begin
                  req_gap_left = $urandom_range(1, 3);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and stall generator.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_rsp.size() == 0) begin
               $error("result beat with no request outstanding");
               error_count++;
            end else begin
               rsp_want = predicted_rsp.pop_front();
               if (rsp_data.status !== rsp_want.status) begin
                  $error("status: expected %0d, got %0d", rsp_want.status, rsp_data.status);
                  error_count++;
               end
               if (rsp_data.granted_index !== rsp_want.granted_index) begin
                  $error("granted_index: expected %0d, got %0d",
                         rsp_want.granted_index, rsp_data.granted_index);
                  error_count++;
               end
               if (rsp_data.blocks_free !== rsp_want.blocks_free) begin
                  $error("blocks_free: expected %0d, got %0d",
                         rsp_want.blocks_free, rsp_data.blocks_free);
                  error_count++;
               end
            end
         end
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_stall_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send(input logic op, input logic [INDEX_W-1:0] index);
      fbpa_req_type r;
      r.op = op;
      r.block_index = index;
      pending_requests.push_back(r);
      requests_queued++;
   endtask

   task automatic wait_until_idle();
      while (requests_taken != requests_queued || predicted_rsp.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_active(input logic [COUNT_W-1:0] value);
      wait_until_idle();
      repeat (4) @(posedge clock);
      csr_write_data <= value;
      csr_write_en <= 1'b1;
      pool_rebuild(value);
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Most free beats name a block inside the pool so that many of them succeed.
   task automatic send_random(input int count, input int alloc_pct);
      logic op;
      logic [INDEX_W-1:0] index;
      for (int i = 0; i < count; i++) begin
         op = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
         if ($urandom_range(0, 9) < 8) begin
            index = INDEX_W'($urandom_range(0, pool_active - 1));
         end else begin
            index = INDEX_W'($urandom_range(0, POOL_SIZE - 1));
         end
         send(op, index);
      end
   endtask

   initial begin
      pool_rebuild(COUNT_W'(POOL_SIZE));
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Full pool after reset: double frees, LIFO reuse, frees of idle blocks.
      send(OP_FREE, 8'd0);
      send(OP_ALLOC, 8'd255);
      send(OP_ALLOC, 8'd0);
      send(OP_ALLOC, 8'd0);
      send(OP_FREE, 8'd1);
      send(OP_FREE, 8'd1);
      send(OP_ALLOC, 8'd0);
      send(OP_FREE, 8'd255);
      send(OP_FREE, 8'd2);
      send(OP_FREE, 8'd0);
      send(OP_ALLOC, 8'd0);

      // A write of zero leaves a pool of one block.
      write_active(9'd0);
      send(OP_ALLOC, 8'd0);
      send(OP_ALLOC, 8'd0);
      send(OP_FREE, 8'd1);
      send(OP_FREE, 8'd255);
      send(OP_FREE, 8'd0);
      send(OP_FREE, 8'd0);
      send(OP_ALLOC, 8'd0);

      write_active(9'd2);
      send(OP_ALLOC, 8'd0);
      send(OP_ALLOC, 8'd0);
      send(OP_ALLOC, 8'd0);
      send(OP_FREE, 8'd0);
      send(OP_FREE, 8'd1);
      send(OP_ALLOC, 8'd0);
      send(OP_ALLOC, 8'd0);

      // Oversized writes saturate to the full pool.
      write_active(9'd511);
      send_random(300, 95);
      wait_until_idle();
      send_random(200, 25);

      write_active(9'd257);
      send_random(60, 50);
      write_active(9'd1);
      send_random(60, 50);
      write_active(9'd3);
      send_random(80, 50);
      write_active(COUNT_W'($urandom_range(4, 40)));
      send_random(150, 55);
      write_active(9'd8);
      send_random(100, 50);
      write_active(COUNT_W'($urandom_range(41, 255)));
      send_random(100, 60);

      write_active(9'd16);
      quiet = 1'b1;
      send_random(100, 50);

      wait_until_idle();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
